FILE: design/gdda_pkg.sv
// ----------------------------------------------------------------------------
// gdda_pkg
// Shared types and constants for the grid ray DDA stepper.
// ----------------------------------------------------------------------------
package gdda_pkg;

  localparam int unsigned POS_W   = 24;
  localparam int unsigned DIR_W   = 16;
  localparam int unsigned RAY_W   = 19;
  localparam int unsigned REM_W   = 20;
  localparam int unsigned QUO_W   = 31;
  localparam int unsigned DIST_W  = 32;
  localparam int unsigned CELL_W  = 10;
  localparam int unsigned STEP_W  = 7;
  localparam int unsigned DIV_CNT_W = 5;
  localparam int unsigned IN_W    = 128;
  localparam int unsigned OUT_W   = 56;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;
  localparam logic [DIV_CNT_W-1:0] DIV_TOP = 5'd30;

  typedef enum logic [2:0] {
    F_IDLE,
    F_PROD,
    F_RAY,
    F_DIV,
    F_MUL,
    F_PUSH
  } front_state_t;

  typedef enum logic {
    B_IDLE,
    B_RUN
  } back_state_t;

  // per-ray start record handed from front to back
  typedef struct packed {
    logic [DIST_W-1:0] side_x;
    logic [DIST_W-1:0] side_y;
    logic [DIST_W-1:0] delta_x;
    logic [DIST_W-1:0] delta_y;
    logic [7:0]        cell_x;
    logic [7:0]        cell_y;
    logic              neg_x;
    logic              neg_y;
  } ray_rec_t;

  // queue handshake toward the back end
  typedef struct packed {
    logic     valid;
    ray_rec_t rec;
  } rec_q_t;

endpackage

FILE: design/gdda_front.sv
// ----------------------------------------------------------------------------
// gdda_front
// Accepts a ray word, forms ray direction, reciprocal deltas by restoring
// division and initial side distances, then pushes a start record.
// ----------------------------------------------------------------------------
module gdda_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [gdda_pkg::IN_W-1:0] in_tdata,
  output logic                    push_valid,
  input  logic                    push_ready,
  output gdda_pkg::ray_rec_t      push_rec
);

  gdda_pkg::front_state_t state_r, state_nxt;

  logic [gdda_pkg::POS_W-1:0]        pos_r   [2];
  logic signed [gdda_pkg::DIR_W-1:0] dir_r   [2];
  logic signed [gdda_pkg::DIR_W-1:0] plane_r [2];
  logic signed [gdda_pkg::DIR_W-1:0] cam_r;
  logic signed [31:0]                prod_r  [2];
  logic signed [gdda_pkg::RAY_W-1:0] ray_r   [2];
  logic [gdda_pkg::REM_W-1:0]        rem_r   [2];
  logic [gdda_pkg::QUO_W-1:0]        quo_r   [2];
  logic [gdda_pkg::DIV_CNT_W-1:0]    cnt_r;
  gdda_pkg::ray_rec_t                rec_r;

  logic [gdda_pkg::RAY_W-1:0]        mag     [2];
  logic [gdda_pkg::REM_W-1:0]        trial   [2];
  logic                              ge      [2];
  logic [16:0]                       frac_f  [2];
  logic [47:0]                       sprod   [2];
  logic [gdda_pkg::DIST_W-1:0]       delta_v [2];
  logic [gdda_pkg::DIST_W-1:0]       side_v  [2];
  logic                              zero_v  [2];

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gdda_pkg::F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and handshakes
  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    push_valid = 1'b0;
    unique case (state_r)
      gdda_pkg::F_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) state_nxt = gdda_pkg::F_PROD;
      end
      gdda_pkg::F_PROD: state_nxt = gdda_pkg::F_RAY;
      gdda_pkg::F_RAY:  state_nxt = gdda_pkg::F_DIV;
      gdda_pkg::F_DIV: begin
        if (cnt_r == '0) state_nxt = gdda_pkg::F_MUL;
      end
      gdda_pkg::F_MUL:  state_nxt = gdda_pkg::F_PUSH;
      gdda_pkg::F_PUSH: begin
        push_valid = 1'b1;
        if (push_ready) state_nxt = gdda_pkg::F_IDLE;
      end
      default: state_nxt = gdda_pkg::F_IDLE;
    endcase
  end

  // per-axis divider step and side distance product
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      zero_v[a]  = (ray_r[a] == '0);
      mag[a]     = ray_r[a][gdda_pkg::RAY_W-1] ? gdda_pkg::RAY_W'(-ray_r[a])
                                               : gdda_pkg::RAY_W'(ray_r[a]);
      trial[a]   = {rem_r[a][gdda_pkg::REM_W-2:0], (cnt_r == gdda_pkg::DIV_TOP)};
      ge[a]      = (trial[a] >= {1'b0, mag[a]});
      frac_f[a]  = ray_r[a][gdda_pkg::RAY_W-1] ? {1'b0, pos_r[a][15:0]}
                                               : 17'h10000 - {1'b0, pos_r[a][15:0]};
      sprod[a]   = 48'(frac_f[a]) * 48'(quo_r[a]);
      delta_v[a] = zero_v[a] ? gdda_pkg::DIST_MAX : {1'b0, quo_r[a]};
      side_v[a]  = zero_v[a] ? gdda_pkg::DIST_MAX : sprod[a][47:16];
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      gdda_pkg::F_IDLE: begin
        pos_r[0]   <= in_tdata[23:0];
        pos_r[1]   <= in_tdata[47:24];
        dir_r[0]   <= in_tdata[63:48];
        dir_r[1]   <= in_tdata[79:64];
        plane_r[0] <= in_tdata[95:80];
        plane_r[1] <= in_tdata[111:96];
        cam_r      <= in_tdata[127:112];
      end
      gdda_pkg::F_PROD: begin
        for (int a = 0; a < 2; a++) prod_r[a] <= plane_r[a] * cam_r;
      end
      gdda_pkg::F_RAY: begin
        for (int a = 0; a < 2; a++) begin
          ray_r[a] <= gdda_pkg::RAY_W'(dir_r[a]) + gdda_pkg::RAY_W'(prod_r[a] >>> 14);
          rem_r[a] <= '0;
          quo_r[a] <= '0;
        end
        cnt_r <= gdda_pkg::DIV_TOP;
      end
      gdda_pkg::F_DIV: begin
        for (int a = 0; a < 2; a++) begin
          rem_r[a] <= ge[a] ? trial[a] - {1'b0, mag[a]} : trial[a];
          quo_r[a] <= {quo_r[a][gdda_pkg::QUO_W-2:0], ge[a]};
        end
        cnt_r <= cnt_r - 1'b1;
      end
      gdda_pkg::F_MUL: begin
        rec_r.delta_x <= delta_v[0];
        rec_r.delta_y <= delta_v[1];
        rec_r.side_x  <= side_v[0];
        rec_r.side_y  <= side_v[1];
        rec_r.cell_x  <= pos_r[0][23:16];
        rec_r.cell_y  <= pos_r[1][23:16];
        rec_r.neg_x   <= ray_r[0][gdda_pkg::RAY_W-1];
        rec_r.neg_y   <= ray_r[1][gdda_pkg::RAY_W-1];
      end
      default: ;
    endcase
  end

  assign push_rec = rec_r;

endmodule

FILE: design/gdda_queue.sv
// ----------------------------------------------------------------------------
// gdda_queue
// Two-entry queue of start records between front and back ends.
// ----------------------------------------------------------------------------
module gdda_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  gdda_pkg::ray_rec_t push_rec,
  output gdda_pkg::rec_q_t   head,
  input  logic               pop
);

  gdda_pkg::ray_rec_t mem [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && (cnt_r != 2'd0);
  assign head.valid = (cnt_r != 2'd0);
  assign head.rec   = mem[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= push_rec;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

FILE: design/gdda_back.sv
// ----------------------------------------------------------------------------
// gdda_back
// Walks the grid from a start record, one cell per cycle while the output
// is not stalled, into an output register, until the step limit or the
// grid edge.
module gdda_back #(
  parameter int unsigned GRID_SIZE = 256,
  parameter int unsigned MAX_RUN   = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [gdda_pkg::STEP_W-1:0]   cfg_wr_data,
  input  gdda_pkg::rec_q_t              head,
  output logic                          pop,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [gdda_pkg::OUT_W-1:0]    out_tdata,
  output logic                          out_tlast
);

  localparam logic signed [gdda_pkg::CELL_W-1:0] GRID_LIM = gdda_pkg::CELL_W'(GRID_SIZE);
  localparam logic [gdda_pkg::STEP_W-1:0]        RUN_LIM  = gdda_pkg::STEP_W'(MAX_RUN);

  gdda_pkg::back_state_t state_r, state_nxt;

  logic [gdda_pkg::STEP_W-1:0]        max_steps_r;
  logic [gdda_pkg::DIST_W-1:0]        side_x_r, side_y_r, delta_x_r, delta_y_r;
  logic signed [gdda_pkg::CELL_W-1:0] cell_x_r, cell_y_r;
  logic                               neg_x_r, neg_y_r;
  logic [gdda_pkg::STEP_W-1:0]        steps_r;
  logic                               out_valid_r;
  logic [gdda_pkg::OUT_W-1:0]         out_data_r;
  logic                               out_last_r;

  logic                               adv, step_en, take_x, outside, fin;
  logic [gdda_pkg::STEP_W-1:0]        limit, steps_nxt;
  logic [gdda_pkg::DIST_W-1:0]        cross_dist;
  logic [gdda_pkg::DIST_W:0]          sum;
  logic [gdda_pkg::DIST_W-1:0]        sat;
  logic signed [gdda_pkg::CELL_W-1:0] nx, ny;

  assign adv = !out_valid_r || out_tready;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gdda_pkg::B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state, queue pop and step enable
  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    step_en   = 1'b0;
    unique case (state_r)
      gdda_pkg::B_IDLE: begin
        if (head.valid) begin
          pop       = 1'b1;
          state_nxt = gdda_pkg::B_RUN;
        end
      end
      gdda_pkg::B_RUN: begin
        step_en = adv;
        if (adv && fin) state_nxt = gdda_pkg::B_IDLE;
      end
      default: state_nxt = gdda_pkg::B_IDLE;
    endcase
  end

  // one dda step
  always_comb begin
    priority if (max_steps_r == '0) limit = 7'd1;
    else if (max_steps_r > RUN_LIM) limit = RUN_LIM;
    else limit = max_steps_r;
    take_x     = (side_x_r < side_y_r);
    cross_dist = take_x ? side_x_r : side_y_r;
    sum    = {1'b0, cross_dist} + {1'b0, take_x ? delta_x_r : delta_y_r};
    sat    = sum[gdda_pkg::DIST_W] ? gdda_pkg::DIST_MAX : sum[gdda_pkg::DIST_W-1:0];
    nx     = cell_x_r;
    ny     = cell_y_r;
    if (take_x) nx = neg_x_r ? cell_x_r - 10'sd1 : cell_x_r + 10'sd1;
    else        ny = neg_y_r ? cell_y_r - 10'sd1 : cell_y_r + 10'sd1;
    steps_nxt = steps_r + 1'b1;
    outside   = (nx < 0) || (nx >= GRID_LIM) || (ny < 0) || (ny >= GRID_LIM);
    fin       = outside || (steps_nxt >= limit);
  end

  // step limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_steps_r <= 7'd64;
    end else if (cfg_wr_en) begin
      max_steps_r <= cfg_wr_data;
    end
  end

  // walk registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_x_r  <= '0;
      side_y_r  <= '0;
      delta_x_r <= '0;
      delta_y_r <= '0;
      cell_x_r  <= '0;
      cell_y_r  <= '0;
      neg_x_r   <= 1'b0;
      neg_y_r   <= 1'b0;
      steps_r   <= '0;
    end else if (pop) begin
      side_x_r  <= head.rec.side_x;
      side_y_r  <= head.rec.side_y;
      delta_x_r <= head.rec.delta_x;
      delta_y_r <= head.rec.delta_y;
      cell_x_r  <= {2'b00, head.rec.cell_x};
      cell_y_r  <= {2'b00, head.rec.cell_y};
      neg_x_r   <= head.rec.neg_x;
      neg_y_r   <= head.rec.neg_y;
      steps_r   <= '0;
    end else if (step_en) begin
      if (take_x) side_x_r <= sat;
      else        side_y_r <= sat;
      cell_x_r <= nx;
      cell_y_r <= ny;
      steps_r  <= steps_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_en) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_data_r <= {2'b00, outside, cross_dist, ~take_x, ny, nx};
      out_last_r <= fin;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

FILE: design/grid_ray_dda_stepper.sv
// ----------------------------------------------------------------------------
// grid_ray_dda_stepper
// Ray setup and DDA grid walk; emits one word per cell crossed.
// An accepted ray word passes the 31-step divider and setup, a queue write
//   and a pop before its first cell word is emitted.
// Throughput: one cell per cycle while out_tready is not held low; the front
//   takes no new ray until its record is pushed, and the queue lets setup overlap the walk.
// Reset: synchronous active-low; clears control and sets max_steps to 64.
// ----------------------------------------------------------------------------
module grid_ray_dda_stepper #(
  parameter int unsigned GRID_SIZE = 256,
  parameter int unsigned MAX_RUN   = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [6:0]   cfg_wr_data,   // max_steps
  input  logic         in_tvalid,
  output logic         in_tready,
  // pos_x, pos_y, dir_x, dir_y, plane_x, plane_y, camera_x
  input  logic [127:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // cell_x, cell_y, side, distance, left_grid, zero pad
  output logic [55:0]  out_tdata,
  output logic         out_tlast
);

  logic               push_valid, push_ready, pop;
  gdda_pkg::ray_rec_t push_rec;
  gdda_pkg::rec_q_t   head;

  gdda_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_rec  (push_rec)
  );

  gdda_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_rec  (push_rec),
    .head      (head),
    .pop       (pop)
  );

  gdda_back #(
    .GRID_SIZE(GRID_SIZE),
    .MAX_RUN  (MAX_RUN)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
